// ===== hdl/pwc_pkg.sv =====
// Shared types and constants for the pulse width capture block.
package pwc_pkg;

	localparam int TIMER_BITS = 16;
	localparam int FRAC_BITS  = 24;
	localparam int CNT_W      = 16;
	localparam int SPAN_W     = 32;
	localparam int WIDTH_W    = 32;
	localparam int PROD_W     = SPAN_W + FRAC_BITS;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	// register indexes (paddr[2])
	localparam logic REG_PULSE_COUNT = 1'b0;
	localparam logic REG_TICK_SCALE  = 1'b1;

	// event kinds on s_tuser
	localparam logic FUNC_OVERFLOW = 1'b0;
	localparam logic FUNC_EDGE     = 1'b1;

	localparam logic [CNT_W-1:0]     PULSE_COUNT_RST = CNT_W'(1);
	localparam logic [FRAC_BITS-1:0] TICK_SCALE_RST  = FRAC_BITS'(279620);
	localparam logic [CNT_W-1:0]     OVF_MAX         = {CNT_W{1'b1}};
	localparam logic [FRAC_BITS-1:0] FRAC_HALF       = FRAC_BITS'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic [CNT_W-1:0]     pulse_count;
		logic [FRAC_BITS-1:0] tick_scale;
	} cfg_t;

endpackage

// ===== hdl/pwc_regs.sv =====
// APB configuration registers: pulse_count and tick_scale.
module pwc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwc_pkg::ADDR_W-1:0]  paddr,
	input  logic [pwc_pkg::DATA_W-1:0]  pwdata,
	output logic [pwc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output pwc_pkg::cfg_t               cfg
);

	logic [pwc_pkg::CNT_W-1:0]     pulse_count_q;
	logic [pwc_pkg::FRAC_BITS-1:0] tick_scale_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q <= pwc_pkg::PULSE_COUNT_RST;
			tick_scale_q  <= pwc_pkg::TICK_SCALE_RST;
		end else if (wr_en) begin
			case (paddr[2])
				pwc_pkg::REG_PULSE_COUNT: pulse_count_q <= pwdata[pwc_pkg::CNT_W-1:0];
				pwc_pkg::REG_TICK_SCALE:  tick_scale_q  <= pwdata[pwc_pkg::FRAC_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pwc_pkg::REG_PULSE_COUNT: prdata = pwc_pkg::DATA_W'(pulse_count_q);
			pwc_pkg::REG_TICK_SCALE:  prdata = pwc_pkg::DATA_W'(tick_scale_q);
			default:                  prdata = '0;
		endcase
	end

	assign cfg.pulse_count = pulse_count_q;
	assign cfg.tick_scale  = tick_scale_q;

endmodule

// ===== hdl/pwc_span.sv =====
// Front stage: overflow counter, previous capture and tick span per edge.
module pwc_span (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         accept,
	input  logic                         func,
	input  logic [pwc_pkg::TIMER_BITS-1:0] capture_value,
	output logic                         edge_v_s1,
	output logic [pwc_pkg::SPAN_W-1:0]   span_s1
);

	logic [pwc_pkg::TIMER_BITS-1:0] prev_q;
	logic [pwc_pkg::CNT_W-1:0]      ovf_q;
	logic [pwc_pkg::SPAN_W-1:0]     base;
	logic [pwc_pkg::SPAN_W-1:0]     span;

	// base term: n periods, one period on wrap, else +1 for inclusive count
	always_comb begin
		if (ovf_q != '0)
			base = {ovf_q, {pwc_pkg::TIMER_BITS{1'b0}}};
		else if (capture_value <= prev_q)
			base = pwc_pkg::SPAN_W'(1) << pwc_pkg::TIMER_BITS;
		else
			base = pwc_pkg::SPAN_W'(1);
		span = base + pwc_pkg::SPAN_W'(capture_value) - pwc_pkg::SPAN_W'(prev_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			ovf_q     <= '0;
			edge_v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (func == pwc_pkg::FUNC_EDGE) begin
					prev_q <= capture_value;
					ovf_q  <= '0;
				end else if (ovf_q != pwc_pkg::OVF_MAX) begin
					ovf_q <= ovf_q + pwc_pkg::CNT_W'(1);
				end
			end
			if (advance)
				edge_v_s1 <= accept && (func == pwc_pkg::FUNC_EDGE);
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			span_s1 <= span;
	end

	a_edge_clears_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (func == pwc_pkg::FUNC_EDGE) |=> ovf_q == '0)
		else $error("overflow count not cleared by edge");

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (func == pwc_pkg::FUNC_OVERFLOW) && (ovf_q == pwc_pkg::OVF_MAX)
		|=> ovf_q == pwc_pkg::OVF_MAX)
		else $error("overflow count wrapped");

	a_prev_follows_edge: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (func == pwc_pkg::FUNC_EDGE) |=> prev_q == $past(capture_value))
		else $error("previous capture not updated");

endmodule

// ===== hdl/pwc_round.sv =====
// Back stages: scale multiply, round to nearest, run tracking and result register.
module pwc_round (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  pwc_pkg::cfg_t               cfg,
	input  logic                        edge_v_s1,
	input  logic [pwc_pkg::SPAN_W-1:0]  span_s1,
	output logic                        m_tvalid,
	output logic [pwc_pkg::WIDTH_W-1:0] m_tdata,
	output logic                        m_tuser,
	output logic                        m_tlast
);

	logic                          edge_v_s2;
	logic [pwc_pkg::PROD_W-1:0]    prod_s2;
	logic [pwc_pkg::CNT_W-1:0]     edges_q;
	logic                          valid_q;
	logic [pwc_pkg::WIDTH_W-1:0]   width_q;
	logic                          err_q;
	logic                          last_q;

	logic [pwc_pkg::WIDTH_W-1:0]   q_int;
	logic [pwc_pkg::FRAC_BITS-1:0] q_frac;
	logic                          round_up;
	logic [pwc_pkg::WIDTH_W-1:0]   width;
	logic                          err;
	logic [pwc_pkg::CNT_W-1:0]     target;
	logic                          fin;
	logic                          seed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			edge_v_s2 <= 1'b0;
		else if (advance)
			edge_v_s2 <= edge_v_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			prod_s2 <= pwc_pkg::PROD_W'(span_s1) * pwc_pkg::PROD_W'(cfg.tick_scale);
	end

	// ties round down; the top integer value absorbs a round-up
	always_comb begin
		q_int    = prod_s2[pwc_pkg::PROD_W-1:pwc_pkg::FRAC_BITS];
		q_frac   = prod_s2[pwc_pkg::FRAC_BITS-1:0];
		round_up = (q_frac > pwc_pkg::FRAC_HALF) && (q_int != '1);
		width    = q_int + pwc_pkg::WIDTH_W'(round_up);
		err      = (width == '0);
		target   = (cfg.pulse_count == '0) ? pwc_pkg::CNT_W'(1) : cfg.pulse_count;
		fin      = err || (edges_q >= target);
		seed     = (edges_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_q <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= edge_v_s2 && !seed;
			if (edge_v_s2) begin
				if (seed)
					edges_q <= pwc_pkg::CNT_W'(1);
				else if (fin)
					edges_q <= '0;
				else
					edges_q <= edges_q + pwc_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			width_q <= width;
			err_q   <= err;
			last_q  <= fin;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = width_q;
	assign m_tuser  = err_q;
	assign m_tlast  = last_q;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && err_q |-> last_q)
		else $error("error result not marked last");

	a_err_zero_width: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && err_q |-> width_q == '0)
		else $error("error result with nonzero width");

	a_seed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && edge_v_s2 && seed |=> !valid_q && edges_q == pwc_pkg::CNT_W'(1))
		else $error("seeding edge produced a result");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && edge_v_s2 && !seed && fin |=> edges_q == '0)
		else $error("run did not restart after last width");

endmodule

// ===== hdl/pulse_width_capture.sv =====
// Top level of the pulse width capture block: streaming in/out, APB configuration.
// An accepted capture edge passes the span register, the product register and the result register in turn.
// Throughput: one event per cycle while the output is not stalled; the 32x24 scale multiply sits in its own stage.
// Overflow ticks and seeding edges give no result. A stalled output holds the whole pipe.
// Reset (arst_n low, asynchronous): run restarts, counters clear, registers take defaults.
module pulse_width_capture (
	input  logic                        clk,
	input  logic                        arst_n,
	// event stream in
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [15:0] capture_value
	input  logic                        s_tuser,   // [0] func: 0 overflow tick, 1 edge
	// width stream out
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,   // [31:0] width_us
	output logic                        m_tuser,   // [0] width_error
	output logic                        m_tlast,   // final width of run or error
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwc_pkg::ADDR_W-1:0]  paddr,
	input  logic [pwc_pkg::DATA_W-1:0]  pwdata,
	output logic [pwc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	pwc_pkg::cfg_t                cfg;
	logic                         advance;
	logic                         accept;
	logic                         edge_v_s1;
	logic [pwc_pkg::SPAN_W-1:0]   span_s1;

	// The pipe moves whenever the result register is empty or being drained,
	// so a new transfer is taken every cycle while the sink keeps up.
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && s_tready;

	pwc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1: overflow counting and span against the previous capture.
	// Previous capture loads on every accepted edge; the overflow count steps on accepted overflow ticks
	// and clears on edges, independent of run position, so no feedback from later stages is needed.
	pwc_span u_span (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.accept        (accept),
		.func          (s_tuser),
		.capture_value (s_tdata),
		.edge_v_s1     (edge_v_s1),
		.span_s1       (span_s1)
	);

	// Stages 2 and 3: multiply by tick_scale, round, then the run counter
	// decides seed / width / last / error and loads the result register.
	pwc_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.cfg       (cfg),
		.edge_v_s1 (edge_v_s1),
		.span_s1   (span_s1),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== tb/sv/pulse_width_capture_tb.sv =====
// Self-checking testbench for pulse_width_capture: directed table, random phases, scoreboard.
module pulse_width_capture_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import pwc_pkg::*;

	// Generous cap: about 450 items, each with a random idle gap, a random stall and the pipe delay,
	// plus the drains around register writes, with wide margin.
	localparam int CYCLE_LIMIT = 100000;
	// After the last expected width arrives a trailing overflow or seeding edge
	// may still be in the pipe, so the drain waits DRAIN_CYCLES longer.
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 65;

	// One expected width transfer.
	typedef struct packed {
		logic [WIDTH_W-1:0] width;
		logic               err;
		logic               fin;
	} width_rec_t;

	typedef enum logic {ROW_EV, ROW_WR} row_kind_e;

	// Directed row: an event (repeated reps times) or a register write.
	// When typed is set the expected width is taken from the row, not the predictor.
	typedef struct packed {
		row_kind_e   kind;
		logic        func;
		logic        reg_idx;
		logic [31:0] value;
		logic [16:0] reps;
		logic        typed;
		logic [31:0] w;
		logic        err;
		logic        fin;
	} stim_row_t;

	localparam int N_ROWS = 30;
	localparam stim_row_t DIR_ROWS [N_ROWS] = '{
		// reset defaults: one width per run, scale about 1/60
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'h0000, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		// cur == prev, no overflow: full timer period, 65536/60 -> 1092
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'h0000, 17'd1, 1'b1, 32'd1092, 1'b0, 1'b1},
		// scale exactly one half: exercises ties
		'{ROW_WR, FUNC_OVERFLOW, REG_TICK_SCALE, 32'h0080_0000, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WR, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'd3, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		// overflows ahead of the first edge are dropped when it seeds
		'{ROW_EV, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'h0000, 17'd3, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'd10, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		// span 3 * 0.5 = 1.5, tie rounds down
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'd12, 17'd1, 1'b1, 32'd1, 1'b0, 1'b0},
		// span 2 -> exactly 1
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'd13, 17'd1, 1'b1, 32'd1, 1'b0, 1'b0},
		'{ROW_EV, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'h0000, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		// one overflow: span 65535, 32767.5 ties down; third width ends the run
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'd12, 17'd1, 1'b1, 32'd32767, 1'b0, 1'b1},
		// just above one half; zero pulse count acts as one
		'{ROW_WR, FUNC_OVERFLOW, REG_TICK_SCALE, 32'h0080_0001, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WR, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'd0, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'hFFFF, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'h0000, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		// smallest span (one tick across the wrap)
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'h0000, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		// zero scale forces a zero width: error ends the run
		'{ROW_WR, FUNC_OVERFLOW, REG_TICK_SCALE, 32'h0000_0000, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WR, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'hFFFE, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'h1234, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'h5678, 17'd1, 1'b1, 32'd0, 1'b1, 1'b1},
		// max scale; pulse count lowered mid run to the number of widths already taken
		'{ROW_WR, FUNC_OVERFLOW, REG_TICK_SCALE, 32'h00FF_FFFF, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WR, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'd5, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'h0000, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'hFFFF, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'hFFFF, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WR, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'd2, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'h0005, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		// a back-to-back overflow burst, then a span of many timer periods
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'hFFFF, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_OVERFLOW, REG_PULSE_COUNT, 32'h0000, 17'd40, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'hFFFF, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_EV, FUNC_EDGE, REG_PULSE_COUNT, 32'h0000, 17'd1, 1'b0, 32'd0, 1'b0, 1'b0}
	};

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [15:0]        s_tdata  = '0;
	logic               s_tuser  = FUNC_OVERFLOW;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [31:0]        m_tdata;
	logic               m_tuser;
	logic               m_tlast;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [ADDR_W-1:0]  paddr    = '0;
	logic [DATA_W-1:0]  pwdata   = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	// predictor copy of the block's registers and state
	logic [CNT_W-1:0]      cfg_pulse_count = PULSE_COUNT_RST;
	logic [FRAC_BITS-1:0]  cfg_tick_scale  = TICK_SCALE_RST;
	logic [TIMER_BITS-1:0] prev_cap        = '0;
	logic [CNT_W-1:0]      ovf_cnt         = '0;
	logic [CNT_W-1:0]      run_edges       = '0;

	width_rec_t width_q [$];
	int         mismatch_count = 0;
	int         cycle_count    = 0;
	int         stall_left     = 0;
	bit         quiet_run      = 1'b0;

	pulse_width_capture dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** pulse_width_capture: FAILED **");
			$finish;
		end
	end

	function automatic int draw_gap();
		return quiet_run ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Steps the capture state by one event; returns 1 with the width when one is due.
	function automatic bit advance_capture(input logic func, input logic [15:0] cap,
			output width_rec_t rec);
		logic [63:0]      span;
		logic [63:0]      prod;
		logic [63:0]      q;
		logic [CNT_W-1:0] goal;
		rec = '0;
		if (func == FUNC_OVERFLOW) begin
			if (ovf_cnt != OVF_MAX)
				ovf_cnt++;
			return 1'b0;
		end
		if (run_edges == 0) begin
			// first edge of a run only seeds; stray overflows are dropped
			prev_cap  = cap;
			ovf_cnt   = '0;
			run_edges = CNT_W'(1);
			return 1'b0;
		end
		if (ovf_cnt != 0)
			span = (64'(ovf_cnt) << TIMER_BITS) - 64'(prev_cap) + 64'(cap);
		else if (cap <= prev_cap)
			span = (64'd1 << TIMER_BITS) - 64'(prev_cap) + 64'(cap);
		else
			span = 64'(cap) - 64'(prev_cap) + 64'd1;
		prod = span * 64'(cfg_tick_scale);
		q = prod >> FRAC_BITS;
		if (prod[FRAC_BITS-1:0] > FRAC_HALF)
			q++;
		if (q > 64'hFFFF_FFFF)
			q = 64'hFFFF_FFFF;
		goal      = (cfg_pulse_count == 0) ? CNT_W'(1) : cfg_pulse_count;
		rec.width = q[WIDTH_W-1:0];
		rec.err   = (q == 0);
		rec.fin   = rec.err || (run_edges >= goal);
		run_edges = rec.fin ? CNT_W'(0) : run_edges + 1'b1;
		prev_cap  = cap;
		ovf_cnt   = '0;
		return 1'b1;
	endfunction

	// Offers one event after the given idle gap and returns at the edge it transfers.
	// Valid stays high when the next call draws no gap.
	task automatic transfer_event(input int gap, input logic func, input logic [15:0] cap,
			input bit typed, input width_rec_t typed_rec);
		width_rec_t rec;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= cap;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (advance_capture(func, cap, rec))
			width_q.push_back(typed ? typed_rec : rec);
	endtask

	// Quiet the input and wait until every expected width is out and the pipe is empty.
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		while (width_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_PULSE_COUNT)
			cfg_pulse_count = val[CNT_W-1:0];
		else
			cfg_tick_scale = val[FRAC_BITS-1:0];
	endtask

	// Result side back-pressure: a random stall after each width transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= (stall_left == 0);
		end else if (m_tvalid && m_tready) begin
			stall_left = draw_gap();
			m_tready <= (stall_left == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Width scoreboard: each transfer against the oldest expectation.
	always @(posedge clk) begin
		width_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (width_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected width %0d err %0b last %0b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = width_q.pop_front();
				if (m_tdata !== want.width)
					flag_mismatch($sformatf("width_us got %0d want %0d", m_tdata, want.width));
				if (m_tuser !== want.err)
					flag_mismatch($sformatf("width_error got %b want %b", m_tuser, want.err));
				if (m_tlast !== want.fin)
					flag_mismatch($sformatf("last got %b want %b", m_tlast, want.fin));
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] wdata;
		logic [15:0]       cap;
		logic              func;
		width_rec_t        typed_rec;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; overflow bursts go back to back
		for (int r = 0; r < N_ROWS; r++) begin
			if (DIR_ROWS[r].kind == ROW_WR) begin
				drain_pipe();
				apb_write(DIR_ROWS[r].reg_idx, DIR_ROWS[r].value);
			end else begin
				typed_rec = '{DIR_ROWS[r].w, DIR_ROWS[r].err, DIR_ROWS[r].fin};
				for (int k = 0; k < DIR_ROWS[r].reps; k++)
					transfer_event(DIR_ROWS[r].reps > 1 ? 0 : draw_gap(), DIR_ROWS[r].func,
						DIR_ROWS[r].value[15:0], DIR_ROWS[r].typed, typed_rec);
			end
		end

		// random phases: new settings each phase, runs mostly short so they finish
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_pipe();
			wdata = $urandom;
			case ($urandom_range(0, 6))
				0:       wdata[15:0] = 16'h0000;
				1:       wdata[15:0] = 16'hFFFF;
				2:       wdata[15:0] = 16'hFFFE;
				default: wdata[15:0] = 16'($urandom_range(1, 6));
			endcase
			apb_write(REG_PULSE_COUNT, wdata);
			drain_pipe();
			wdata = $urandom;
			case ($urandom_range(0, 6))
				0:       wdata[23:0] = 24'h000000;
				1:       wdata[23:0] = 24'hFFFFFF;
				2:       wdata[23:0] = TICK_SCALE_RST;
				3:       wdata[23:0] = 24'($urandom_range(0, 4));
				4:       wdata[23:0] = 24'h800000;
				default: wdata[23:0] = 24'($urandom);
			endcase
			apb_write(REG_TICK_SCALE, wdata);
			quiet_run = (p % 3 == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				func = ($urandom_range(0, 99) < 60) ? FUNC_EDGE : FUNC_OVERFLOW;
				// edges near the previous capture hit the wrap and short-span corners
				case ($urandom_range(0, 9))
					0:       cap = prev_cap;
					1:       cap = prev_cap + 1'b1;
					2:       cap = prev_cap - 1'b1;
					3:       cap = 16'h0000;
					4:       cap = 16'hFFFF;
					default: cap = 16'($urandom);
				endcase
				transfer_event(draw_gap(), func, cap, 1'b0, '0);
			end
		end

		quiet_run = 1'b0;
		drain_pipe();
		if (mismatch_count == 0)
			$display("** pulse_width_capture: PASSED **");
		else
			$display("** pulse_width_capture: FAILED **");
		$finish;
	end

endmodule

// ===== pulse_width_capture.f =====
hdl/pwc_pkg.sv
hdl/pwc_regs.sv
hdl/pwc_span.sv
hdl/pwc_round.sv
hdl/pulse_width_capture.sv
tb/sv/pulse_width_capture_tb.sv
